@@ sv/sbip_pkg.sv @@
package sbip_pkg;

    localparam int PIX_W       = 8;
    localparam int MODE_W      = 4;
    localparam int IN_TDATA_W  = 104;  // 64 above + 32 left + 8 corner
    localparam int IN_TUSER_W  = 6;    // mode, top flag, left flag
    localparam int OUT_TDATA_W = 128;  // four 32-bit rows

    localparam logic [PIX_W-1:0] TOP_FILL  = 8'd127;
    localparam logic [PIX_W-1:0] LEFT_FILL = 8'd129;
    localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;

    typedef enum logic [MODE_W-1:0] {
        MODE_DC = 4'd0,
        MODE_TM = 4'd1,
        MODE_VE = 4'd2,
        MODE_HE = 4'd3,
        MODE_LD = 4'd4,
        MODE_RD = 4'd5,
        MODE_VR = 4'd6,
        MODE_VL = 4'd7,
        MODE_HD = 4'd8,
        MODE_HU = 4'd9
    } mode_t;

    // rounded 2-tap average
    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] x,
                                              input logic [PIX_W-1:0] y);
        logic [PIX_W:0] s;
        s = {1'b0, x} + {1'b0, y} + {{PIX_W{1'b0}}, 1'b1};
        return s[PIX_W:1];
    endfunction

    // rounded 3-tap average, weights 1-2-1
    function automatic logic [PIX_W-1:0] avg3(input logic [PIX_W-1:0] x,
                                              input logic [PIX_W-1:0] y,
                                              input logic [PIX_W-1:0] z);
        logic [PIX_W+1:0] s;
        s = {2'b00, x} + {1'b0, y, 1'b0} + {2'b00, z} + 10'd2;
        return s[PIX_W+1:2];
    endfunction

    // clamp a signed 10-bit sum to a pixel
    function automatic logic [PIX_W-1:0] clip8(input logic signed [PIX_W+1:0] v);
        logic [PIX_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({2'b00, PIX_MAX}))
        begin
            r = PIX_MAX;
        end
        else
        begin
            r = v[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/subblock_intra_predictor_4x4.sv @@
// 4x4 subblock intra predictor (VP8 style). One input beat carries the
// neighbours of a block and a mode; one output beat carries the 4x4
// prediction as four packed rows. The datapath is an input register, one
// level of averaging/clipping logic and an output register, so a new beat
// is taken every cycle while the output side keeps up; an accepted beat passes
// through the input and then the output register. Throughput is set by the single
// output register: when the output is stalled, the input register holds one
// more beat and tready then drops. Edge substitution (127 above, 129 left,
// corner 127 at the top edge else 129 at the left edge) is done here; the
// caller supplies above-right pixels already resolved. Modes 10..15 predict
// as DC. No configuration, no state between blocks.
module subblock_intra_predictor_4x4
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [63:0] above_pixels, [95:64] left_pixels, [103:96] corner_pixel
    input  logic [sbip_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [3:0] pred_mode, [4] at_top_edge, [5] at_left_edge
    input  logic [sbip_pkg::IN_TUSER_W-1:0]    s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] row0, [63:32] row1, [95:64] row2, [127:96] row3
    output logic [sbip_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int PW = sbip_pkg::PIX_W;

    // input stage
    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [sbip_pkg::MODE_W-1:0] mode_reg;
    logic [8*PW-1:0]             above_reg;
    logic [4*PW-1:0]             left_reg;
    logic [PW-1:0]               corner_reg;
    logic                        top_reg;
    logic                        ledge_reg;

    // output stage
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [sbip_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [sbip_pkg::OUT_TDATA_W-1:0] out_data_next;

    logic in_beat;
    logic out_load;

    // output register free this cycle -> input stage may move on
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_beat)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mode_reg   <= s_axis_tuser[3:0];
            top_reg    <= s_axis_tuser[4];
            ledge_reg  <= s_axis_tuser[5];
            above_reg  <= s_axis_tdata[63:0];
            left_reg   <= s_axis_tdata[95:64];
            corner_reg <= s_axis_tdata[103:96];
        end
        if (out_load && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------
    logic [PW-1:0]   a [8];   // above, after edge fill
    logic [PW-1:0]   l [4];   // left, after edge fill
    logic [PW-1:0]   p;       // corner, after edge fill
    logic [PW-1:0]   e [9];   // edge run: left bottom-up, corner, above
    logic [PW-1:0]   b [16];  // block, raster order
    logic [PW+2:0]   dc_sum;
    logic [PW-1:0]   dc;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            a[i] = top_reg ? sbip_pkg::TOP_FILL : above_reg[PW*i +: PW];
        end
        for (int i = 0; i < 4; i++)
        begin
            l[i] = ledge_reg ? sbip_pkg::LEFT_FILL : left_reg[PW*i +: PW];
        end
        p = top_reg ? sbip_pkg::TOP_FILL :
            (ledge_reg ? sbip_pkg::LEFT_FILL : corner_reg);

        e[0] = l[3];
        e[1] = l[2];
        e[2] = l[1];
        e[3] = l[0];
        e[4] = p;
        e[5] = a[0];
        e[6] = a[1];
        e[7] = a[2];
        e[8] = a[3];

        dc_sum = 11'd4;
        for (int i = 0; i < 4; i++)
        begin
            dc_sum = dc_sum + {3'b000, a[i]} + {3'b000, l[i]};
        end
        dc = dc_sum[PW+2:3];

        for (int i = 0; i < 16; i++)
        begin
            b[i] = dc;
        end

        unique case (mode_reg)
            sbip_pkg::MODE_DC:
            begin
                // already filled
            end
            sbip_pkg::MODE_TM:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        b[r*4+c] = sbip_pkg::clip8($signed({2'b00, l[r]})
                                                 + $signed({2'b00, a[c]})
                                                 - $signed({2'b00, p}));
                    end
                end
            end
            sbip_pkg::MODE_VE:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        b[r*4+c] = sbip_pkg::avg3((c == 0) ? p : a[(c == 0) ? 0 : c-1],
                                                  a[c], a[c+1]);
                    end
                end
            end
            sbip_pkg::MODE_HE:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        b[r*4+c] = sbip_pkg::avg3((r == 0) ? p : l[(r == 0) ? 0 : r-1],
                                                  l[r],
                                                  (r == 3) ? l[3] : l[(r == 3) ? 3 : r+1]);
                    end
                end
            end
            sbip_pkg::MODE_LD:
            begin
                // one 3-tap average per anti-diagonal, last tap clamped to A7
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        b[r*4+c] = sbip_pkg::avg3(a[r+c], a[r+c+1],
                                                  a[(r+c+2 > 7) ? 7 : r+c+2]);
                    end
                end
            end
            sbip_pkg::MODE_RD:
            begin
                // diagonal c-r centred on the corner of the edge run
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        b[r*4+c] = sbip_pkg::avg3(e[3+c-r], e[4+c-r], e[5+c-r]);
                    end
                end
            end
            sbip_pkg::MODE_VR:
            begin
                b[12] = sbip_pkg::avg3(e[1], e[2], e[3]);
                b[8]  = sbip_pkg::avg3(e[2], e[3], e[4]);
                b[4]  = sbip_pkg::avg3(e[3], e[4], e[5]);
                b[13] = b[4];
                b[0]  = sbip_pkg::avg2(e[4], e[5]);
                b[9]  = b[0];
                b[5]  = sbip_pkg::avg3(e[4], e[5], e[6]);
                b[14] = b[5];
                b[1]  = sbip_pkg::avg2(e[5], e[6]);
                b[10] = b[1];
                b[6]  = sbip_pkg::avg3(e[5], e[6], e[7]);
                b[15] = b[6];
                b[2]  = sbip_pkg::avg2(e[6], e[7]);
                b[11] = b[2];
                b[7]  = sbip_pkg::avg3(e[6], e[7], e[8]);
                b[3]  = sbip_pkg::avg2(e[7], e[8]);
            end
            sbip_pkg::MODE_VL:
            begin
                b[0]  = sbip_pkg::avg2(a[0], a[1]);
                b[4]  = sbip_pkg::avg3(a[0], a[1], a[2]);
                b[1]  = sbip_pkg::avg2(a[1], a[2]);
                b[8]  = b[1];
                b[5]  = sbip_pkg::avg3(a[1], a[2], a[3]);
                b[12] = b[5];
                b[2]  = sbip_pkg::avg2(a[2], a[3]);
                b[9]  = b[2];
                b[6]  = sbip_pkg::avg3(a[2], a[3], a[4]);
                b[13] = b[6];
                b[3]  = sbip_pkg::avg2(a[3], a[4]);
                b[10] = b[3];
                b[7]  = sbip_pkg::avg3(a[3], a[4], a[5]);
                b[14] = b[7];
                // the two irregular taps at the right edge
                b[11] = sbip_pkg::avg3(a[4], a[5], a[6]);
                b[15] = sbip_pkg::avg3(a[5], a[6], a[7]);
            end
            sbip_pkg::MODE_HD:
            begin
                b[12] = sbip_pkg::avg2(e[0], e[1]);
                b[13] = sbip_pkg::avg3(e[0], e[1], e[2]);
                b[8]  = sbip_pkg::avg2(e[1], e[2]);
                b[14] = b[8];
                b[9]  = sbip_pkg::avg3(e[1], e[2], e[3]);
                b[15] = b[9];
                b[4]  = sbip_pkg::avg2(e[2], e[3]);
                b[10] = b[4];
                b[5]  = sbip_pkg::avg3(e[2], e[3], e[4]);
                b[11] = b[5];
                b[0]  = sbip_pkg::avg2(e[3], e[4]);
                b[6]  = b[0];
                b[1]  = sbip_pkg::avg3(e[3], e[4], e[5]);
                b[7]  = b[1];
                b[2]  = sbip_pkg::avg3(e[4], e[5], e[6]);
                b[3]  = sbip_pkg::avg3(e[5], e[6], e[7]);
            end
            sbip_pkg::MODE_HU:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    b[i] = l[3];
                end
                b[0] = sbip_pkg::avg2(l[0], l[1]);
                b[1] = sbip_pkg::avg3(l[0], l[1], l[2]);
                b[2] = sbip_pkg::avg2(l[1], l[2]);
                b[4] = b[2];
                b[3] = sbip_pkg::avg3(l[1], l[2], l[3]);
                b[5] = b[3];
                b[6] = sbip_pkg::avg2(l[2], l[3]);
                b[8] = b[6];
                b[7] = sbip_pkg::avg3(l[2], l[3], l[3]);
                b[9] = b[7];
            end
            default:
            begin
                // unused mode codes fall back to DC
            end
        endcase

        // pixel (r,c) lands at bits 8*(4r+c); row r fills word r
        for (int i = 0; i < 16; i++)
        begin
            out_data_next[PW*i +: PW] = b[i];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ sv/sbip_checker.sv @@
module sbip_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [sbip_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [sbip_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic in_beat;
    logic dc_both_edges;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    // DC with both edges filled: (4*127 + 4*129 + 4) >> 3 = 128 everywhere
    assign dc_both_edges = (s_axis_tuser[3:0] == sbip_pkg::MODE_DC)
                           && s_axis_tuser[4] && s_axis_tuser[5];

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // input only backs up when both stages are full and the output is stalled
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // an output beat after an empty cycle comes from an earlier input beat
    a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_beat, 2))
        else $error("output beat without matching input beat");

    a_dc_edges: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) && $past(in_beat && dc_both_edges, 2)
        |-> m_axis_tdata == {16{8'd128}})
        else $error("DC prediction at picture corner is not flat 128");

endmodule

bind subblock_intra_predictor_4x4 sbip_checker u_sbip_checker (.*);

@@ tb/tb_subblock_intra_predictor_4x4.sv @@
// Self-checking bench for the 4x4 subblock intra predictor.
// A directed set covers every mode, undefined mode codes, clipping in TM and
// the edge substitutions. A random set of about 950 blocks follows.
// Every accepted input beat is run through a behavioral predictor. The
// expected rows wait in a queue until the matching output beat arrives.
module tb_subblock_intra_predictor_4x4;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 950;
    localparam int SETTLE_CYCLES = 16;   // well past the input and output registers
    localparam int MAX_REPORTS  = 10;

    // one block's worth of neighbours plus control
    typedef struct {
        logic [sbip_pkg::MODE_W-1:0] mode;
        logic [63:0]       above;
        logic [31:0]       left;
        logic [7:0]        corner;
        logic              top;
        logic              ledge;
        logic              drain_first;  // hold off until all rows are back
    } blk_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [sbip_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic [sbip_pkg::IN_TUSER_W-1:0]     s_axis_tuser  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [sbip_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;

    blk_t         blk_q[$];        // blocks waiting to be sent
    logic [127:0] pred_rows_q[$];  // predicted rows of accepted blocks
    blk_t         cur_blk;
    int           sent_cnt = 0;
    int           got_cnt  = 0;
    int           err_cnt  = 0;
    int           gap_left = 0;
    int           burst_left = 0;
    int           rx_phase = 0;
    int           rx_tick  = 0;
    int           cycle_cnt = 0;

    subblock_intra_predictor_4x4 i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned mean2(input int unsigned x, input int unsigned y);
        return (x + y + 1) >> 1;
    endfunction

    function automatic int unsigned mean3(input int unsigned x, input int unsigned y,
                                          input int unsigned z);
        return (x + 2 * y + z + 2) >> 2;
    endfunction

    // Behavioral 4x4 prediction; returns row r in bits 32r+31..32r.
    function automatic logic [127:0] predict_block(input blk_t b);
        int unsigned a[8];
        int unsigned l[4];
        int unsigned e[9];
        int unsigned px[16];
        int unsigned cn;
        int unsigned s;
        int          v;
        int          k;
        logic [127:0] rows;
        for (int i = 0; i < 8; i++)
        begin
            a[i] = 32'(b.top ? sbip_pkg::TOP_FILL : b.above[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++)
        begin
            l[i] = 32'(b.ledge ? sbip_pkg::LEFT_FILL : b.left[8*i +: 8]);
        end
        // top edge wins for the corner
        cn = 32'(b.top ? sbip_pkg::TOP_FILL : (b.ledge ? sbip_pkg::LEFT_FILL : b.corner));
        // edge run from bottom-left up through the corner to the top-right
        e[0] = l[3]; e[1] = l[2]; e[2] = l[1]; e[3] = l[0]; e[4] = cn;
        e[5] = a[0]; e[6] = a[1]; e[7] = a[2]; e[8] = a[3];

        case (b.mode)
            sbip_pkg::MODE_TM:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        v = int'(l[r]) + int'(a[c]) - int'(cn);
                        px[r*4+c] = 32'((v < 0) ? 0 :
                                        ((v > int'(sbip_pkg::PIX_MAX)) ?
                                         int'(sbip_pkg::PIX_MAX) : v));
                    end
                end
            end
            sbip_pkg::MODE_VE:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    s = mean3((c == 0) ? cn : a[c-1], a[c], a[c+1]);
                    for (int r = 0; r < 4; r++)
                    begin
                        px[r*4+c] = s;
                    end
                end
            end
            sbip_pkg::MODE_HE:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    s = mean3((r == 0) ? cn : l[r-1], l[r], (r == 3) ? l[3] : l[r+1]);
                    for (int c = 0; c < 4; c++)
                    begin
                        px[r*4+c] = s;
                    end
                end
            end
            sbip_pkg::MODE_LD:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        k = r + c;
                        px[r*4+c] = mean3(a[k], a[k+1], a[(k + 2 > 7) ? 7 : k + 2]);
                    end
                end
            end
            sbip_pkg::MODE_RD:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        k = 4 + c - r;
                        px[r*4+c] = mean3(e[k-1], e[k], e[k+1]);
                    end
                end
            end
            sbip_pkg::MODE_VR:
            begin
                px[12] = mean3(e[1], e[2], e[3]);
                px[8]  = mean3(e[2], e[3], e[4]);
                px[4]  = mean3(e[3], e[4], e[5]);  px[13] = px[4];
                px[0]  = mean2(e[4], e[5]);        px[9]  = px[0];
                px[5]  = mean3(e[4], e[5], e[6]);  px[14] = px[5];
                px[1]  = mean2(e[5], e[6]);        px[10] = px[1];
                px[6]  = mean3(e[5], e[6], e[7]);  px[15] = px[6];
                px[2]  = mean2(e[6], e[7]);        px[11] = px[2];
                px[7]  = mean3(e[6], e[7], e[8]);
                px[3]  = mean2(e[7], e[8]);
            end
            sbip_pkg::MODE_VL:
            begin
                px[0]  = mean2(a[0], a[1]);
                px[4]  = mean3(a[0], a[1], a[2]);
                px[1]  = mean2(a[1], a[2]);        px[8]  = px[1];
                px[5]  = mean3(a[1], a[2], a[3]);  px[12] = px[5];
                px[2]  = mean2(a[2], a[3]);        px[9]  = px[2];
                px[6]  = mean3(a[2], a[3], a[4]);  px[13] = px[6];
                px[3]  = mean2(a[3], a[4]);        px[10] = px[3];
                px[7]  = mean3(a[3], a[4], a[5]);  px[14] = px[7];
                // the two odd taps in the last column
                px[11] = mean3(a[4], a[5], a[6]);
                px[15] = mean3(a[5], a[6], a[7]);
            end
            sbip_pkg::MODE_HD:
            begin
                px[12] = mean2(e[0], e[1]);
                px[13] = mean3(e[0], e[1], e[2]);
                px[8]  = mean2(e[1], e[2]);        px[14] = px[8];
                px[9]  = mean3(e[1], e[2], e[3]);  px[15] = px[9];
                px[4]  = mean2(e[2], e[3]);        px[10] = px[4];
                px[5]  = mean3(e[2], e[3], e[4]);  px[11] = px[5];
                px[0]  = mean2(e[3], e[4]);        px[6]  = px[0];
                px[1]  = mean3(e[3], e[4], e[5]);  px[7]  = px[1];
                px[2]  = mean3(e[4], e[5], e[6]);
                px[3]  = mean3(e[5], e[6], e[7]);
            end
            sbip_pkg::MODE_HU:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    px[i] = l[3];
                end
                px[0] = mean2(l[0], l[1]);
                px[1] = mean3(l[0], l[1], l[2]);
                px[2] = mean2(l[1], l[2]);        px[4] = px[2];
                px[3] = mean3(l[1], l[2], l[3]);  px[5] = px[3];
                px[6] = mean2(l[2], l[3]);        px[8] = px[6];
                px[7] = mean3(l[2], l[3], l[3]);  px[9] = px[7];
            end
            default:
            begin
                // DC, also taken by the undefined codes
                s = 4;
                for (int i = 0; i < 4; i++)
                begin
                    s += a[i] + l[i];
                end
                s = s >> 3;
                for (int i = 0; i < 16; i++)
                begin
                    px[i] = s;
                end
            end
        endcase

        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                rows[32*r + 8*c +: 8] = 8'(px[r*4+c]);
            end
        end
        return rows;
    endfunction

    task automatic add_blk(input logic [sbip_pkg::MODE_W-1:0] mode, input logic [63:0] above,
                           input logic [31:0] left, input logic [7:0] corner,
                           input logic top, input logic ledge, input logic drain_first);
        blk_t b;
        b.mode = mode; b.above = above; b.left = left; b.corner = corner;
        b.top = top; b.ledge = ledge; b.drain_first = drain_first;
        blk_q.push_back(b);
    endtask

    // Driver: bursts of beats separated by random gaps. A beat whose
    // drain_first flag is set waits until every predicted block is back.
    always @(posedge clk or negedge rst_n)
    begin : drv
        int next_sent;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            sent_cnt      <= 0;
            gap_left   = 0;
            burst_left = 0;
        end
        else
        begin
            next_sent = sent_cnt;
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred_rows_q.push_back(predict_block(cur_blk));
                next_sent = sent_cnt + 1;
            end
            sent_cnt <= next_sent;

            if (s_axis_tvalid && !s_axis_tready)
            begin
                // beat still pending, hold it
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (blk_q.size() == 0 || (blk_q[0].drain_first && next_sent != got_cnt))
            begin
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                cur_blk = blk_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {cur_blk.corner, cur_blk.left, cur_blk.above};
                s_axis_tuser  <= {cur_blk.ledge, cur_blk.top, cur_blk.mode};
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Monitor: checks each output beat against the oldest prediction and
    // runs the receiver's stall pattern, which is redrawn periodically from its tick counter.
    always @(posedge clk or negedge rst_n)
    begin : mon
        logic [127:0] want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            got_cnt       <= 0;
            rx_phase = 0;
            rx_tick  = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_cnt <= got_cnt + 1;
                if (pred_rows_q.size() == 0)
                begin
                    if (err_cnt < MAX_REPORTS)
                    begin
                        $display("unexpected output beat: %h", m_axis_tdata);
                    end
                    err_cnt++;
                end
                else
                begin
                    want = pred_rows_q.pop_front();
                    for (int r = 0; r < 4; r++)
                    begin
                        if (m_axis_tdata[32*r +: 32] !== want[32*r +: 32])
                        begin
                            if (err_cnt < MAX_REPORTS)
                            begin
                                $display("block %0d row%0d: expected %h, got %h",
                                         got_cnt, r, want[32*r +: 32],
                                         m_axis_tdata[32*r +: 32]);
                            end
                            err_cnt++;
                        end
                    end
                end
            end

            rx_tick++;
            if (rx_tick[6:0] == 7'd0)
            begin
                rx_phase = $urandom_range(0, 3);
            end
            case (rx_phase)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_tick[3:0] >= 4'd11);  // long stalls
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stim
        logic [sbip_pkg::MODE_W-1:0] m;
        logic [63:0]       above;
        logic [31:0]       left;
        logic [7:0]        corner;
        int                kind;

        // every defined mode on plain random neighbours
        for (int i = 0; i <= sbip_pkg::MODE_HU; i++)
        begin
            add_blk(sbip_pkg::MODE_W'(i), {$urandom, $urandom}, $urandom, 8'($urandom),
                    1'b0, 1'b0, 1'b0);
        end
        // undefined codes fall back to DC
        for (int i = sbip_pkg::MODE_HU + 1; i < 16; i++)
        begin
            add_blk(sbip_pkg::MODE_W'(i), {$urandom, $urandom}, $urandom, 8'($urandom),
                    1'b0, 1'b0, 1'b0);
        end
        // TM saturating high and low
        add_blk(sbip_pkg::MODE_TM, '1, '1, 8'h00, 1'b0, 1'b0, 1'b0);
        add_blk(sbip_pkg::MODE_TM, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0);
        // edge substitution: top only, left only, both (corner takes 127)
        add_blk(sbip_pkg::MODE_TM, {$urandom, $urandom}, $urandom, 8'($urandom),
                1'b1, 1'b0, 1'b0);
        add_blk(sbip_pkg::MODE_HU, {$urandom, $urandom}, $urandom, 8'($urandom),
                1'b0, 1'b1, 1'b0);
        add_blk(sbip_pkg::MODE_RD, {$urandom, $urandom}, $urandom, 8'($urandom),
                1'b1, 1'b1, 1'b1);
        // distinct above-right pixels for the last VL column
        add_blk(sbip_pkg::MODE_VL, 64'hF0C8_9060_3010_0800, $urandom, 8'($urandom),
                1'b0, 1'b0, 1'b0);
        add_blk(sbip_pkg::MODE_DC, '1, '1, 8'hFF, 1'b0, 1'b0, 1'b0);
        add_blk(sbip_pkg::MODE_LD, '1, '0, 8'h00, 1'b0, 1'b0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            m = ($urandom_range(0, 9) == 0) ?
                sbip_pkg::MODE_W'($urandom_range(sbip_pkg::MODE_HU + 1, 15)) :
                sbip_pkg::MODE_W'($urandom_range(0, sbip_pkg::MODE_HU));
            above  = {$urandom, $urandom};
            left   = $urandom;
            corner = 8'($urandom);
            kind   = $urandom_range(0, 7);
            if (kind == 0)
            begin
                above = '1; left = '1; corner = 8'h00;
            end
            else if (kind == 1)
            begin
                above = '0; left = '0; corner = 8'hFF;
            end
            add_blk(m, above, left, corner, ($urandom_range(0, 3) == 0),
                    ($urandom_range(0, 3) == 0), (i % 317 == 316));
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (blk_q.size() != 0 || s_axis_tvalid || sent_cnt != got_cnt)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (pred_rows_q.size() != 0)
        begin
            $display("%0d predicted blocks never came out", pred_rows_q.size());
        end
        if (err_cnt == 0 && pred_rows_q.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/sbip_pkg.sv
sv/subblock_intra_predictor_4x4.sv
sv/sbip_checker.sv
tb/tb_subblock_intra_predictor_4x4.sv
